FILE: rtl/baro_temp_pressure_compensation_macros.svh
// Assertion helpers for the compensation block.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BTPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the cycle after its antecedent.
`define BTPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/btpc_pkg.sv
package btpc_pkg;

  localparam int RawW  = 24;
  localparam int OutW  = 24;
  localparam int AccW  = 192;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] REG_TEMP    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_A = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_B = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_C = 2'd3;

  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

endpackage

FILE: rtl/btpc_req_if.sv
interface btpc_req_if
  import btpc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [RawW-1:0] raw_sample;
  modport source (output valid, req_type, raw_sample, input ready);
  modport sink (input valid, req_type, raw_sample, output ready);
endinterface

FILE: rtl/btpc_res_if.sv
interface btpc_res_if
  import btpc_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   result_kind;
  logic signed [OutW-1:0] temperature;
  logic [OutW-1:0]        pressure;
  logic                   clipped;
  modport source (output valid, result_kind, temperature, pressure, clipped, input ready);
  modport sink (input valid, result_kind, temperature, pressure, clipped, output ready);
endinterface

FILE: rtl/btpc_cfg_if.sv
interface btpc_cfg_if
  import btpc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/baro_temp_pressure_compensation.sv
// Channel   Direction  Payload
// in_req    sink       req_type, raw_sample
// out_res   source     result_kind, temperature, pressure, clipped
// cfg       sink       index (0..3), data (register value)
//
// A request runs through one shared 33x27 signed multiplier under a small
// sequencer. Each term passes a load state, its multiplies (one cycle per 32-bit
// slice of the 192-bit running product in each multiply) and an accumulate state;
// a finish state ends the request. Temperature: 3 multiplies; pressure: 24
// multiplies. in_ready returns in the same cycle that the result becomes valid.
// rst_n is synchronous and clears the calibration registers, the stored
// temperature and the control state. in_ready is high whenever the sequencer is
// idle; the finish cycle stalls only while an earlier result still waits for out_ready.
`include "baro_temp_pressure_compensation_macros.svh"
module baro_temp_pressure_compensation
  import btpc_pkg::*;
#(
  parameter int TEMP_FRAC_BITS  = 16,
  parameter int PRESS_FRAC_BITS = 6
) (
  input logic clk,
  input logic rst_n,
  btpc_req_if.sink   in_req,
  btpc_res_if.source out_res,
  btpc_cfg_if.sink   cfg
);

  // Common binary exponent of the pressure sum.
  localparam int E0 = (37 + 3 * TEMP_FRAC_BITS > 65) ? 37 + 3 * TEMP_FRAC_BITS : 65;
  localparam int EXP = (48 + TEMP_FRAC_BITS > E0) ? 48 + TEMP_FRAC_BITS : E0;
  localparam int PSH = EXP - PRESS_FRAC_BITS;
  localparam int TSH = 48 - TEMP_FRAC_BITS;
  localparam int F = TEMP_FRAC_BITS;

  // Sequencer program: each step multiplies the work register by one operand.

  logic [39:0] tc_r;
  logic [47:0] pa_r, pb_r;
  logic [31:0] pc_r;
  logic signed [OutW-1:0] lt_r;

  state_t state_r, state_nxt;
  logic kind_r;
  logic [RawW-1:0] raw_r;
  logic [3:0] term_r;     // current term
  logic [2:0] pow_r;      // remaining multiplies for this term
  logic [1:0] ppow_r;     // remaining raw powers
  logic signed [AccW-1:0] work_r;  // running product
  logic signed [AccW-1:0] acc_r;
  logic signed [25:0] d_r;
  logic res_valid_r, res_kind_r, res_clip_r;
  logic signed [OutW-1:0] res_t_r;
  logic [OutW-1:0] res_p_r;

  logic [3:0] nterms;
  assign nterms = kind_r ? 4'd11 : 4'd2;

  // Term table: coefficient, raw power, temperature power, denominator.
  logic signed [31:0] t_coef;
  logic [1:0] t_rp, t_lp;
  int t_den;
  always_comb begin
    t_coef = '0; t_rp = 2'd0; t_lp = 2'd0; t_den = 0;
    if (!kind_r) begin
      case (term_r)
        4'd0: begin t_coef = {16'd0, tc_r[31:16]}; t_rp = 2'd1; t_den = 30; end
        default: begin t_coef = {{24{tc_r[39]}}, tc_r[39:32]}; t_rp = 2'd2; t_den = 48; end
      endcase
    end else begin
      case (term_r)
        4'd0: begin t_coef = {16'd0, pb_r[15:0]}; t_den = -3; end
        4'd1: begin t_coef = {16'd0, pb_r[31:16]}; t_lp = 2'd1; t_den = 6 + F; end
        4'd2: begin t_coef = {{24{pb_r[39]}}, pb_r[39:32]}; t_lp = 2'd2; t_den = 8 + 2 * F; end
        4'd3: begin t_coef = {{24{pb_r[47]}}, pb_r[47:40]}; t_lp = 2'd3; t_den = 15 + 3 * F; end
        4'd4: begin
          t_coef = {{16{pa_r[15]}}, pa_r[15:0]} - 32'sd16384; t_rp = 2'd1; t_den = 20;
        end
        4'd5: begin
          t_coef = {{16{pa_r[31]}}, pa_r[31:16]} - 32'sd16384; t_rp = 2'd1; t_lp = 2'd1;
          t_den = 29 + F;
        end
        4'd6: begin
          t_coef = {{24{pa_r[39]}}, pa_r[39:32]}; t_rp = 2'd1; t_lp = 2'd2; t_den = 32 + 2 * F;
        end
        4'd7: begin
          t_coef = {{24{pa_r[47]}}, pa_r[47:40]}; t_rp = 2'd1; t_lp = 2'd3; t_den = 37 + 3 * F;
        end
        4'd8: begin t_coef = {{16{pc_r[15]}}, pc_r[15:0]}; t_rp = 2'd2; t_den = 48; end
        4'd9: begin
          t_coef = {{24{pc_r[23]}}, pc_r[23:16]}; t_rp = 2'd2; t_lp = 2'd1; t_den = 48 + F;
        end
        default: begin t_coef = {{24{pc_r[31]}}, pc_r[31:24]}; t_rp = 2'd3; t_den = 65; end
      endcase
    end
  end

  // Total number of multiplies of the term being loaded; a raw power of one with
  // a cubed temperature needs four.
  logic [2:0] t_pow;
  assign t_pow = {1'b0, t_rp} + {1'b0, t_lp};

  // Temperature terms use d as the multiplied operand and a common exponent of 48.
  logic [7:0] term_shift;
  assign term_shift = kind_r ? 8'(EXP - t_den) : 8'(48 - t_den);

  // Shared multiplier: the running product is split into 32-bit slices?
  // Values stay below 2^130 here, but multiplying the wide product by a 26-bit
  // operand is done one 32-bit slice per cycle.
  logic [2:0] slice_r;
  logic signed [AccW-1:0] prod_r;
  logic signed [26:0] opnd;
  always_comb begin
    if (!kind_r) opnd = 27'(d_r);
    else if (ppow_r != 2'd0) opnd = {3'd0, raw_r};
    else opnd = 27'(lt_r);
  end
  logic [31:0] wslice;
  assign wslice = work_r[slice_r*32 +: 32];
  logic signed [59:0] pp;
  assign pp = $signed({1'b0, wslice}) * opnd;
  localparam logic [2:0] LastSlice = 3'd5;

  logic signed [AccW-1:0] pp_ext;
  assign pp_ext = AccW'(pp) <<< (slice_r * 32);
  logic signed [AccW-1:0] sum_prod;
  // Top slice is signed.
  logic signed [59:0] pps;
  assign pps = $signed(wslice) * opnd;
  assign sum_prod = prod_r + ((slice_r == LastSlice) ? (AccW'(pps) <<< 160) : pp_ext);

  logic signed [AccW-1:0] rnd, fin;
  always_comb begin
    rnd = acc_r + (kind_r ? (AccW'(1) <<< (PSH - 1)) : (AccW'(1) <<< (TSH - 1)));
    fin = kind_r ? (rnd >>> PSH) : (rnd >>> TSH);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_req.valid && in_req.ready) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = (t_pow == 3'd0) ? ST_ACC : ST_MUL;
      ST_MUL:  if (slice_r == LastSlice && pow_r == 3'd1) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (term_r == nterms - 4'd1) ? ST_DONE : ST_LOAD;
      ST_DONE: if (!res_valid_r || out_res.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_req.ready = (state_r == ST_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tc_r <= '0; pa_r <= '0; pb_r <= '0; pc_r <= '0;
      lt_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg.valid) begin
        case (cfg.index)
          REG_TEMP:    tc_r <= cfg.data[39:0];
          REG_PRESS_A: pa_r <= cfg.data;
          REG_PRESS_B: pb_r <= cfg.data;
          REG_PRESS_C: pc_r <= cfg.data[31:0];
          default: ;
        endcase
      end
      if (state_r == ST_DONE && (!res_valid_r || out_res.ready)) res_valid_r <= 1'b1;
      else if (out_res.ready) res_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_req.valid && in_req.ready) begin
          kind_r <= in_req.req_type;
          raw_r <= in_req.raw_sample;
          d_r <= $signed({2'b0, in_req.raw_sample}) - $signed({2'b0, tc_r[15:0], 8'd0});
          term_r <= '0;
          acc_r <= '0;
        end
        ST_LOAD: begin
          work_r <= AccW'(t_coef);
          ppow_r <= t_rp;
          pow_r <= t_pow;
          slice_r <= '0;
          prod_r <= '0;
        end
        ST_MUL: begin
          if (slice_r == LastSlice) begin
            work_r <= sum_prod;
            prod_r <= '0;
            slice_r <= '0;
            pow_r <= pow_r - 3'd1;
            if (ppow_r != 2'd0) ppow_r <= ppow_r - 2'd1;
          end else begin
            prod_r <= sum_prod;
            slice_r <= slice_r + 3'd1;
          end
        end
        ST_ACC: begin
          acc_r <= acc_r + (work_r <<< term_shift);
          term_r <= term_r + 4'd1;
        end
        ST_DONE: if (!res_valid_r || out_res.ready) begin
          res_kind_r <= kind_r;
          if (!kind_r) begin
            res_p_r <= '0;
            if (fin > AccW'(8388607)) begin
              lt_r <= 24'sh7FFFFF; res_t_r <= 24'sh7FFFFF; res_clip_r <= 1'b1;
            end else if (fin < -AccW'(8388608)) begin
              lt_r <= -24'sh800000; res_t_r <= -24'sh800000; res_clip_r <= 1'b1;
            end else begin
              lt_r <= fin[23:0]; res_t_r <= fin[23:0]; res_clip_r <= 1'b0;
            end
          end else begin
            res_t_r <= lt_r;
            if (fin < 0) begin
              res_p_r <= '0; res_clip_r <= 1'b1;
            end else if (fin > AccW'(24'hFFFFFF)) begin
              res_p_r <= 24'hFFFFFF; res_clip_r <= 1'b1;
            end else begin
              res_p_r <= fin[23:0]; res_clip_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_res.valid = res_valid_r;
  assign out_res.result_kind = res_kind_r;
  assign out_res.temperature = res_t_r;
  assign out_res.pressure = res_p_r;
  assign out_res.clipped = res_clip_r;

  `BTPC_ASSERT_IMP(a_busy_not_ready, state_r != ST_IDLE, !in_req.ready)
  `BTPC_ASSERT_IMP(a_temp_no_press, out_res.valid && out_res.result_kind == KIND_TEMP,
    out_res.pressure == '0)
  `BTPC_ASSERT_NEXT(a_accept_load, in_req.valid && in_req.ready, state_r == ST_LOAD)

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Self-checking testbench for the barometric compensation block.
// A behavioral predictor evaluates the temperature linearization and the
// cubic pressure polynomial in wide signed integers, keeps its own copy of
// the calibration words and the stored temperature, and queues one expected
// result per accepted request. A monitor compares every accepted result with
// the oldest expectation. Both handshakes idle in random bursts, except in
// the final phase of the run.
module tb
  import btpc_pkg::*;
();

  localparam int CycleLimit = 2000000;
  // The exponent that puts every polynomial term on one integer grid.
  localparam int GridExp = 85;
  localparam int PressShift = GridExp - 6;

  typedef struct packed {
    logic             kind;
    logic signed [23:0] temperature;
    logic [23:0]      pressure;
    logic             clipped;
  } comp_result_t;

  logic clk;
  logic rst_n;

  btpc_req_if in_req();
  btpc_res_if out_res();
  btpc_cfg_if cfg();

  baro_temp_pressure_compensation dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req.sink),
    .out_res(out_res.source),
    .cfg    (cfg.sink)
  );

  // Predictor copy of the calibration words and of the stored temperature.
  logic [39:0] temp_cal;
  logic [47:0] press_cal_a;
  logic [47:0] press_cal_b;
  logic [31:0] press_cal_c;
  logic signed [23:0] stored_temp;

  comp_result_t pending_results[$];
  int error_count;
  int cycle_count;
  int temp_requests;
  int press_requests;
  int clipped_results;
  int checked_results;
  bit idling_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL baro_temp_pressure_compensation");
      $finish;
    end
  end

  // One polynomial term, coef * raw^rp * temp^lp / 2^den, on the 2^GridExp grid.
  function automatic logic signed [255:0] poly_term(longint coef, longint raw, int rp,
                                                     longint lt, int lp, int den);
    logic signed [255:0] m;
    m = coef;
    for (int i = 0; i < rp; i++) m = m * raw;
    for (int i = 0; i < lp; i++) m = m * lt;
    return m <<< (GridExp - den);
  endfunction

  // Work out the result of one request and advance the stored temperature.
  function automatic comp_result_t compensate(logic kind, logic [23:0] raw);
    comp_result_t r;
    longint t1, t2, t3, d, num, q, lt, rw;
    logic signed [255:0] acc;
    logic signed [255:0] half;
    r = '0;
    r.kind = kind;
    if (kind == KIND_TEMP) begin
      t1 = longint'(temp_cal[15:0]);
      t2 = longint'(temp_cal[31:16]);
      t3 = longint'($signed(temp_cal[39:32]));
      d = longint'(raw) - t1 * 256;
      num = t2 * d * 262144 + d * d * t3 + (longint'(1) <<< 31);
      q = num >>> 32;
      if (q > 8388607) begin
        q = 8388607;
        r.clipped = 1'b1;
      end
      if (q < -8388608) begin
        q = -8388608;
        r.clipped = 1'b1;
      end
      stored_temp = q[23:0];
    end else begin
      lt = longint'(stored_temp);
      rw = longint'(raw);
      acc = poly_term(longint'(press_cal_b[15:0]), rw, 0, lt, 0, -3);
      acc += poly_term(longint'(press_cal_b[31:16]), rw, 0, lt, 1, 22);
      acc += poly_term(longint'($signed(press_cal_b[39:32])), rw, 0, lt, 2, 40);
      acc += poly_term(longint'($signed(press_cal_b[47:40])), rw, 0, lt, 3, 63);
      acc += poly_term(longint'($signed(press_cal_a[15:0])) - 16384, rw, 1, lt, 0, 20);
      acc += poly_term(longint'($signed(press_cal_a[31:16])) - 16384, rw, 1, lt, 1, 45);
      acc += poly_term(longint'($signed(press_cal_a[39:32])), rw, 1, lt, 2, 64);
      acc += poly_term(longint'($signed(press_cal_a[47:40])), rw, 1, lt, 3, 85);
      acc += poly_term(longint'($signed(press_cal_c[15:0])), rw, 2, lt, 0, 48);
      acc += poly_term(longint'($signed(press_cal_c[23:16])), rw, 2, lt, 1, 64);
      acc += poly_term(longint'($signed(press_cal_c[31:24])), rw, 3, lt, 0, 65);
      half = 1;
      acc = (acc + (half <<< (PressShift - 1))) >>> PressShift;
      if (acc < 0) begin
        r.pressure = '0;
        r.clipped = 1'b1;
      end else if (acc > 256'sd16777215) begin
        r.pressure = 24'hFFFFFF;
        r.clipped = 1'b1;
      end else begin
        r.pressure = acc[23:0];
      end
    end
    r.temperature = stored_temp;
    return r;
  endfunction

  task automatic idle_burst();
    if (idling_on && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 11)) @(negedge clk);
  endtask

  // Send one request and queue its expected result once it is accepted.
  task automatic send_request(logic kind, logic [23:0] raw);
    idle_burst();
    in_req.valid = 1'b1;
    in_req.req_type = kind;
    in_req.raw_sample = raw;
    do @(posedge clk); while (!in_req.ready);
    pending_results.push_back(compensate(kind, raw));
    if (kind == KIND_TEMP) temp_requests++;
    else press_requests++;
    @(negedge clk);
    in_req.valid = 1'b0;
  endtask

  // Wait until every expected result has arrived, then let the block settle.
  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Calibration writes happen only while the block is idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    drain();
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_TEMP: begin
        temp_cal = value[39:0];
      end
      REG_PRESS_A: begin
        press_cal_a = value[47:0];
      end
      REG_PRESS_B: begin
        press_cal_b = value[47:0];
      end
      REG_PRESS_C: begin
        press_cal_c = value[31:0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic load_calibration(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                                  logic [47:0] pc);
    write_reg(REG_TEMP, tc);
    write_reg(REG_PRESS_A, pa);
    write_reg(REG_PRESS_B, pb);
    write_reg(REG_PRESS_C, pc);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Coefficients near those of a real sensor, so that most results stay in range.
  task automatic load_typical_calibration();
    logic [15:0] t1, t2, p1, p2, p5, p6, p9;
    logic [7:0] t3, p3, p4, p7, p8, p10, p11;
    t1 = 16'($urandom_range(26000, 28000));
    t2 = 16'($urandom_range(18000, 20000));
    t3 = 8'(-$urandom_range(3, 8));
    p1 = 16'($urandom_range(0, 4000) - 2000);
    p2 = 16'($urandom_range(0, 4000) - 2000);
    p3 = 8'($urandom_range(0, 40) - 20);
    p4 = 8'($urandom_range(0, 10) - 5);
    p5 = 16'($urandom_range(20000, 27000));
    p6 = 16'($urandom_range(25000, 32000));
    p7 = 8'($urandom_range(0, 20) - 10);
    p8 = 8'($urandom_range(0, 20) - 10);
    p9 = 16'($urandom_range(0, 8000) - 4000);
    p10 = 8'($urandom_range(0, 20) - 10);
    p11 = 8'($urandom_range(0, 40) - 20);
    load_calibration({8'h00, t3, t2, t1}, {p4, p3, p2, p1}, {p8, p7, p6, p5},
                     {16'h0000, p11, p10, p9});
  endtask

  // After reset all words are zero and the stored temperature is zero, so a
  // pressure request before any temperature uses that zero temperature.
  task automatic test_reset_state();
    send_request(KIND_PRESS, 24'h000000);
    send_request(KIND_PRESS, 24'hFFFFFF);
    send_request(KIND_TEMP, 24'h000000);
    send_request(KIND_TEMP, 24'hFFFFFF);
  endtask

  // Temperature saturation on both sides and an in-range point.
  task automatic test_temperature_extremes();
    load_calibration(48'h00_FFFF_0000, '0, '0, '0);
    send_request(KIND_TEMP, 24'hFFFFFF);
    load_calibration(48'hFF_FFFF_FFFF, '0, '0, '0);
    send_request(KIND_TEMP, 24'h000000);
    load_calibration(48'h7F_FFFF_0000, '0, '0, '0);
    send_request(KIND_TEMP, 24'hFFFFFF);
    load_calibration(48'h80_0000_FFFF, '0, '0, '0);
    send_request(KIND_TEMP, 24'h000000);
    load_calibration(48'h00_4A38_6978, '0, '0, '0);
    send_request(KIND_TEMP, 24'h7F0000);
    send_request(KIND_PRESS, 24'h6C0000);
  endtask

  // Pressure that falls below zero and pressure that exceeds the output range.
  task automatic test_pressure_clipping();
    load_calibration(48'h00_4A38_6978, 48'h0000_4000_4000, 48'h0000_0000_FFFF, '0);
    send_request(KIND_TEMP, 24'h7F0000);
    send_request(KIND_PRESS, 24'h123456);
    load_calibration(48'h00_4A38_6978, 48'h0000_4000_8000, 48'h0000_0000_0000, '0);
    send_request(KIND_PRESS, 24'hFFFFFF);
    load_calibration(48'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                     48'hFFFF_FFFF_FFFF);
    send_request(KIND_TEMP, 24'hFFFFFF);
    send_request(KIND_PRESS, 24'hFFFFFF);
    send_request(KIND_PRESS, 24'h000000);
  endtask

  // Data bits above each register's width are dropped by the block.
  task automatic test_register_width();
    load_calibration(48'hFFFF_FFFF_FFFF, 48'h8080_8000_8000, 48'h7F7F_7FFF_7FFF,
                     48'hFFFF_8080_8000);
    send_request(KIND_TEMP, 24'h800000);
    send_request(KIND_PRESS, 24'h800000);
    send_request(KIND_PRESS, 24'h000001);
  endtask

  // Random phases: mostly a temperature followed by pressure readings, as a
  // sensor driver issues them, with stray orderings mixed in.
  task automatic test_random_phases();
    logic kind;
    logic [47:0] tc_word;
    for (int phase = 0; phase < 8; phase++) begin
      idling_on = (phase != 7);
      case (phase % 4)
        0: load_typical_calibration();
        1: load_calibration(rand48(), rand48(), rand48(), rand48());
        2: begin
          load_typical_calibration();
          write_reg(REG_PRESS_C, rand48());
        end
        default: begin
          tc_word = rand48();
          load_calibration({8'h00, (($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7F),
                            tc_word[31:0]}, rand48(), rand48(), rand48());
        end
      endcase
      for (int n = 0; n < 200; n++) begin
        if (n % 8 == 0 || $urandom_range(0, 15) == 0) kind = KIND_TEMP;
        else kind = KIND_PRESS;
        if ($urandom_range(0, 3) != 0 && phase % 2 == 0)
          send_request(kind, kind == KIND_TEMP ? 24'($urandom_range(7000000, 9000000))
                                               : 24'($urandom_range(5000000, 7500000)));
        else
          send_request(kind, 24'($urandom()));
      end
    end
  endtask

  // Result monitor with random back-pressure on out_res.ready.
  initial begin
    int stall_left;
    comp_result_t exp_res;
    stall_left = 0;
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_res.valid && out_res.ready) begin
        checked_results++;
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (exp_res.clipped) clipped_results++;
          if (out_res.result_kind !== exp_res.kind) begin
            $error("result_kind expected %0d got %0d", exp_res.kind, out_res.result_kind);
            error_count++;
          end
          if (out_res.temperature !== exp_res.temperature) begin
            $error("temperature expected %0d got %0d", exp_res.temperature,
                   out_res.temperature);
            error_count++;
          end
          if (out_res.pressure !== exp_res.pressure) begin
            $error("pressure expected %0d got %0d", exp_res.pressure, out_res.pressure);
            error_count++;
          end
          if (out_res.clipped !== exp_res.clipped) begin
            $error("clipped expected %0d got %0d", exp_res.clipped, out_res.clipped);
            error_count++;
          end
        end
      end
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_res.ready = 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_res.ready = 1'b0;
      end else begin
        out_res.ready = 1'b1;
      end
    end
  end

  initial begin
    int settle;
    error_count = 0;
    temp_requests = 0;
    press_requests = 0;
    clipped_results = 0;
    checked_results = 0;
    idling_on = 1'b1;
    temp_cal = '0;
    press_cal_a = '0;
    press_cal_b = '0;
    press_cal_c = '0;
    stored_temp = '0;
    in_req.valid = 1'b0;
    in_req.req_type = KIND_TEMP;
    in_req.raw_sample = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_TEMP;
    cfg.data = '0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_temperature_extremes();
    test_pressure_clipping();
    test_register_width();
    test_random_phases();

    settle = 0;
    while (pending_results.size() != 0 && settle < 20000) begin
      @(negedge clk);
      settle++;
    end
    repeat (40) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end

    $display("Run covered %0d temperature and %0d pressure requests.",
             temp_requests, press_requests);
    $display("Checked %0d results, %0d of them saturated.", checked_results, clipped_results);
    if (error_count == 0) begin
      $display("PASS baro_temp_pressure_compensation");
    end else begin
      $display("FAIL baro_temp_pressure_compensation");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/btpc_pkg.sv
rtl/btpc_req_if.sv
rtl/btpc_res_if.sv
rtl/btpc_cfg_if.sv
rtl/baro_temp_pressure_compensation.sv
tb/tb.sv
